// File: rtl/cffi_pkg.sv
// ----------------------------------------------------------------------------
// cffi_pkg
// Shared sizes, codes and helper functions of the coarse-to-fine face
// interpolator: store geometry, register indexes, weights and rounding.
// ----------------------------------------------------------------------------
package cffi_pkg;

   localparam int unsigned A_MAX       = 32;
   localparam int unsigned B_MAX       = 32;
   localparam int unsigned NUM_VARS    = 5;
   localparam int unsigned NUM_PLANES  = 3;
   localparam int unsigned STORE_DEPTH = NUM_PLANES * A_MAX * B_MAX * NUM_VARS;
   localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

   // exact weighted sum: 64 times a 32-bit value needs 38 bits, plus margin
   localparam int unsigned ACC_W = 40;

   // reads per fine sub-cell: three planes of four coarse cells
   localparam logic [3:0] LAST_STEP = 4'd11;

   // transaction kinds
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_INTERP = 1'b1;

   // configuration register indexes
   localparam logic [2:0] CSR_FACE_SELECT    = 3'd0;
   localparam logic [2:0] CSR_FIRST_COARSE_A = 3'd1;
   localparam logic [2:0] CSR_FIRST_COARSE_B = 3'd2;
   localparam logic [2:0] CSR_COARSE_LAST_A  = 3'd3;
   localparam logic [2:0] CSR_COARSE_LAST_B  = 3'd4;

   localparam logic [5:0] FIRST_COARSE_RST = 6'd1;
   localparam logic [5:0] COARSE_LAST_RST  = 6'd32;

   // in-plane weights in sixteenths
   localparam logic [4:0] W_CELL = 5'd9;
   localparam logic [4:0] W_SIDE = 5'd3;
   localparam logic [4:0] W_DIAG = 5'd1;

   // reads at a missing address yield zero
   function automatic logic store_ok(input logic [1:0] plane, input logic [6:0] a,
                                     input logic [6:0] b, input logic [2:0] v);
      return (32'(plane) < NUM_PLANES) && (a != 7'd0) && (32'(a) <= A_MAX) &&
             (b != 7'd0) && (32'(b) <= B_MAX) && (32'(v) < NUM_VARS);
   endfunction

   function automatic logic [ADDR_W-1:0] store_addr(input logic [1:0] plane,
                                                    input logic [6:0] a,
                                                    input logic [6:0] b,
                                                    input logic [2:0] v);
      logic [31:0] t;
      t = ((32'(plane) * A_MAX + 32'(a) - 32'd1) * B_MAX + 32'(b) - 32'd1) * NUM_VARS +
          32'(v);
      return t[ADDR_W-1:0];
   endfunction

   // neighbour index: step down or up, raise to 1, then lower to the clamp
   function automatic logic [6:0] neighbour(input logic [5:0] c, input logic up,
                                            input logic [5:0] last_c);
      logic [6:0] n;
      if (up) begin
         n = {1'b0, c} + 7'd1;
      end else if (c <= 6'd1) begin
         n = 7'd1;
      end else begin
         n = {1'b0, c} - 7'd1;
      end
      if (n > {1'b0, last_c}) begin
         n = {1'b0, last_c};
      end
      return n;
   endfunction

   // (coarse - first) * 2 + sub + 1, modulo 128
   function automatic logic [6:0] fine_index(input logic [5:0] c, input logic [5:0] first,
                                             input logic sub);
      logic [6:0] diff;
      diff = {1'b0, c} - {1'b0, first};
      return {diff[5:0], sub} + 7'd1;
   endfunction

   // divide by 64 rounding half up, saturate to 32 bits
   function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] q;
      q = (x + ACC_W'(32)) >>> 6;
      if (q[ACC_W-1:31] != {(ACC_W - 31){q[ACC_W-1]}}) begin
         return q[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return q[31:0];
   endfunction

endpackage

// File: rtl/coarse_to_fine_face_interpolator.sv
// ----------------------------------------------------------------------------
// coarse_to_fine_face_interpolator
// Trilinear prolongation of coarse face data onto the fine ghost cells,
// with one single-port coarse store and one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : request channel, valid/ready. kind load writes one signed Q16.16
//            coarse value into the store (plane, coarse_a, coarse_b, variable);
//            kind interpolate names one coarse cell and one variable.
//   rsp_*  : result channel, valid/ready. Four transactions per interpolate,
//            sub-cell along a outer, along b inner; rsp_last marks the fourth.
//   csr_*  : write port for the face and clamp registers, taken at any edge
//            with csr_we high; write only while the block is idle.
// Timing
//   A load is written into the store at the edge that takes it. Each result
//   needs twelve store reads, one per cycle through the single store port,
//   then a drain state to finish the sum and an emit state to round it; the
//   request side turns ready again at the edge that registers the last result.
//   While a result is held by a stalled receiver the next result finishes its
//   reads and then waits; the request side stays not ready until all four
//   results of an interpolate are registered.
// Reset
//   Synchronous, active high: state, valid flags and face registers reset;
//   no result is pending. The store is not cleared; read only what was loaded.
// ----------------------------------------------------------------------------
module coarse_to_fine_face_interpolator
   import cffi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [1:0]         req_plane,
   input  logic [5:0]         req_coarse_a,
   input  logic [5:0]         req_coarse_b,
   input  logic [2:0]         req_variable,
   input  logic signed [31:0] req_value,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [6:0]         rsp_fine_a,
   output logic [6:0]         rsp_fine_b,
   output logic [2:0]         rsp_var_out,
   output logic signed [31:0] rsp_ghost_first,
   output logic signed [31:0] rsp_ghost_second,
   output logic               rsp_last,

   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [5:0]         csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;

   logic [5:0]              first_a_ff, first_b_ff, last_a_ff, last_b_ff;

   logic [5:0]              ca_ff, ca_in, cb_ff, cb_in;
   logic [2:0]              var_ff, var_in;
   logic [1:0]              sub_ff, sub_in;
   logic [3:0]              step_ff, step_in;

   // read pipeline: what to do with the data the store returns next cycle
   logic                    rd_pend_ff, rd_pend_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic [4:0]              wt_ff, wt_in;
   logic                    add_first_ff, add_first_in;
   logic                    add_second_ff, add_second_in;

   logic signed [ACC_W-1:0] acc_first_ff, acc_first_in;
   logic signed [ACC_W-1:0] acc_second_ff, acc_second_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [6:0]              fine_a_ff, fine_a_in, fine_b_ff, fine_b_in;
   logic [2:0]              var_out_ff, var_out_in;
   logic signed [31:0]      ghost_first_ff, ghost_first_in;
   logic signed [31:0]      ghost_second_ff, ghost_second_in;
   logic                    last_ff, last_in;

   logic [31:0]             store [STORE_DEPTH];
   logic [31:0]             mem_q_ff;
   logic [ADDR_W-1:0]       mem_addr;
   logic                    mem_we;

   logic                    req_take;
   logic [6:0]              na, nb, rd_a, rd_b;
   logic [1:0]              rd_plane;
   logic signed [ACC_W-1:0] term, prod;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   assign na = neighbour(ca_ff, sub_ff[1], last_a_ff);
   assign nb = neighbour(cb_ff, sub_ff[0], last_b_ff);

   // step order: plane major, then cell, a-neighbour, b-neighbour, diagonal
   assign rd_plane = step_ff[3:2];
   assign rd_a     = step_ff[0] ? na : {1'b0, ca_ff};
   assign rd_b     = step_ff[1] ? nb : {1'b0, cb_ff};

   assign mem_we = req_take && (req_kind == KIND_LOAD) &&
                   store_ok(req_plane, {1'b0, req_coarse_a}, {1'b0, req_coarse_b},
                            req_variable);

   always_comb begin
      if (state_ff == ST_IDLE) begin
         mem_addr = store_addr(req_plane, {1'b0, req_coarse_a}, {1'b0, req_coarse_b},
                               req_variable);
      end else begin
         mem_addr = store_addr(rd_plane, rd_a, rd_b, var_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_addr] <= req_value;
      end
      mem_q_ff <= store[mem_addr];
   end

   // shared multiply-accumulate on the returned word
   assign term = rd_ok_ff ? ACC_W'($signed(mem_q_ff)) : '0;
   assign prod = term * $signed({{(ACC_W - 5){1'b0}}, wt_ff});

   always_comb begin
      state_in        = state_ff;
      ca_in           = ca_ff;
      cb_in           = cb_ff;
      var_in          = var_ff;
      sub_in          = sub_ff;
      step_in         = step_ff;
      rd_pend_in      = 1'b0;
      rd_ok_in        = rd_ok_ff;
      wt_in           = wt_ff;
      add_first_in    = add_first_ff;
      add_second_in   = add_second_ff;
      acc_first_in    = acc_first_ff;
      acc_second_in   = acc_second_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      fine_a_in       = fine_a_ff;
      fine_b_in       = fine_b_ff;
      var_out_in      = var_out_ff;
      ghost_first_in  = ghost_first_ff;
      ghost_second_in = ghost_second_ff;
      last_in         = last_ff;

      if (rd_pend_ff) begin
         if (add_first_ff) begin
            acc_first_in = acc_first_ff + prod;
         end
         if (add_second_ff) begin
            acc_second_in = acc_second_ff + prod;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_kind == KIND_INTERP)) begin
               ca_in         = req_coarse_a;
               cb_in         = req_coarse_b;
               var_in        = req_variable;
               sub_in        = 2'd0;
               step_in       = 4'd0;
               acc_first_in  = '0;
               acc_second_in = '0;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            rd_pend_in    = 1'b1;
            rd_ok_in      = store_ok(rd_plane, rd_a, rd_b, var_ff);
            add_first_in  = (rd_plane != 2'd2);
            add_second_in = (rd_plane != 2'd0);
            unique case (step_ff[1:0])
               2'd0:    wt_in = W_CELL;
               2'd3:    wt_in = W_DIAG;
               default: wt_in = W_SIDE;
            endcase
            // middle plane carries three quarters in both ghost values
            if (rd_plane == 2'd1) begin
               wt_in = 5'((wt_in << 1) + wt_in);
            end
            step_in = step_ff + 4'd1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               fine_a_in       = fine_index(ca_ff, first_a_ff, sub_ff[1]);
               fine_b_in       = fine_index(cb_ff, first_b_ff, sub_ff[0]);
               var_out_in      = var_ff;
               ghost_first_in  = round_sat(acc_first_ff);
               ghost_second_in = round_sat(acc_second_ff);
               last_in         = (sub_ff == 2'd3);
               if (sub_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end else begin
                  sub_in        = sub_ff + 2'd1;
                  step_in       = 4'd0;
                  acc_first_in  = '0;
                  acc_second_in = '0;
                  state_in      = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         first_a_ff   <= FIRST_COARSE_RST;
         first_b_ff   <= FIRST_COARSE_RST;
         last_a_ff    <= COARSE_LAST_RST;
         last_b_ff    <= COARSE_LAST_RST;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FIRST_COARSE_A: first_a_ff <= csr_wdata;
               CSR_FIRST_COARSE_B: first_b_ff <= csr_wdata;
               CSR_COARSE_LAST_A:  last_a_ff  <= csr_wdata;
               CSR_COARSE_LAST_B:  last_b_ff  <= csr_wdata;
               // face label has no effect on the data path
               CSR_FACE_SELECT: ;
               default: ;
            endcase
         end
      end
      ca_ff           <= ca_in;
      cb_ff           <= cb_in;
      var_ff          <= var_in;
      sub_ff          <= sub_in;
      step_ff         <= step_in;
      rd_ok_ff        <= rd_ok_in;
      wt_ff           <= wt_in;
      add_first_ff    <= add_first_in;
      add_second_ff   <= add_second_in;
      acc_first_ff    <= acc_first_in;
      acc_second_ff   <= acc_second_in;
      fine_a_ff       <= fine_a_in;
      fine_b_ff       <= fine_b_in;
      var_out_ff      <= var_out_in;
      ghost_first_ff  <= ghost_first_in;
      ghost_second_ff <= ghost_second_in;
      last_ff         <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fine_a       = fine_a_ff;
   assign rsp_fine_b       = fine_b_ff;
   assign rsp_var_out      = var_out_ff;
   assign rsp_ghost_first  = ghost_first_ff;
   assign rsp_ghost_second = ghost_second_ff;
   assign rsp_last         = last_ff;

   // a load transaction never produces a result
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_kind == KIND_LOAD)) |=> !$rose(rsp_valid))
      else $error("result raised after a load");

   // store data is only folded into the sum while an interpolate is running
   assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff != ST_IDLE))
      else $error("read pending while idle");

   // the fourth result of an interpolate frees the request side
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && rsp_last) |-> req_ready)
      else $error("request side still busy after last result");

   // no store write while an interpolate is reading
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_IDLE) && !rd_pend_ff)
      else $error("store written during interpolate");

endmodule

// File: sim/coarse_to_fine_face_interpolator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coarse_to_fine_face_interpolator_tb
// Drives load and interpolate transactions into the face interpolator, keeps a
// shadow copy of the coarse store and the face registers, computes the four
// fine ghost results of each interpolate and checks them in order at the
// result port. Both channels idle at random except in the closing phase; the face registers are
// reprogrammed between phases while the block is drained.
// ----------------------------------------------------------------------------
module coarse_to_fine_face_interpolator_tb
   import cffi_pkg::*;
();

   typedef struct packed {
      logic               kind;
      logic [1:0]         plane;
      logic [5:0]         coarse_a;
      logic [5:0]         coarse_b;
      logic [2:0]         vsel;
      logic signed [31:0] value;
   } face_req_type;

   typedef struct packed {
      logic [6:0]         fine_a;
      logic [6:0]         fine_b;
      logic [2:0]         var_out;
      logic signed [31:0] ghost_first;
      logic signed [31:0] ghost_second;
      logic               last;
   } fine_cell_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_kind = 1'b0;
   logic [1:0]         req_plane = '0;
   logic [5:0]         req_coarse_a = '0;
   logic [5:0]         req_coarse_b = '0;
   logic [2:0]         req_variable = '0;
   logic signed [31:0] req_value = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [6:0]         rsp_fine_a;
   logic [6:0]         rsp_fine_b;
   logic [2:0]         rsp_var_out;
   logic signed [31:0] rsp_ghost_first;
   logic signed [31:0] rsp_ghost_second;
   logic               rsp_last;

   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [5:0]         csr_wdata = '0;

   always #4 clock = ~clock;

   coarse_to_fine_face_interpolator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_plane        (req_plane),
      .req_coarse_a     (req_coarse_a),
      .req_coarse_b     (req_coarse_b),
      .req_variable     (req_variable),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_fine_a       (rsp_fine_a),
      .rsp_fine_b       (rsp_fine_b),
      .rsp_var_out      (rsp_var_out),
      .rsp_ghost_first  (rsp_ghost_first),
      .rsp_ghost_second (rsp_ghost_second),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   face_req_type       req_queue[$];
   fine_cell_type      expected_cells[$];
   face_req_type       drv_item;

   // shadow of the coarse store, and which entries the stimulus has loaded
   logic signed [31:0] coarse_copy [STORE_DEPTH];
   bit                 filled [STORE_DEPTH];

   logic [2:0]         cfg_face    = 3'd0;
   logic [5:0]         cfg_first_a = FIRST_COARSE_RST;
   logic [5:0]         cfg_first_b = FIRST_COARSE_RST;
   logic [5:0]         cfg_last_a  = COARSE_LAST_RST;
   logic [5:0]         cfg_last_b  = COARSE_LAST_RST;

   int                 items_queued   = 0;
   int                 items_accepted = 0;
   int                 mismatches     = 0;
   int                 send_gap       = 0;
   int                 recv_stall     = 0;
   int                 fill_mode      = 0;
   bit                 calm           = 1'b0;
   bit                 drv_busy;

   function automatic bit in_store(int p, int a, int b, int v);
      return p >= 0 && p < int'(NUM_PLANES) && a >= 1 && a <= int'(A_MAX) &&
             b >= 1 && b <= int'(B_MAX) && v >= 0 && v < int'(NUM_VARS);
   endfunction

   function automatic int store_index(int p, int a, int b, int v);
      return ((p * int'(A_MAX) + a - 1) * int'(B_MAX) + b - 1) * int'(NUM_VARS) + v;
   endfunction

   function automatic longint coarse_at(int p, int a, int b, int v);
      if (!in_store(p, a, b, v)) begin
         return 0;
      end
      return longint'(coarse_copy[store_index(p, a, b, v)]);
   endfunction

   function automatic int clamp_neighbour(int c, int up, int last_c);
      int n;
      n = up ? c + 1 : c - 1;
      if (n < 1) begin
         n = 1;
      end
      if (n > last_c) begin
         n = last_c;
      end
      return n;
   endfunction

   // floor((x + 32) / 64), saturated to 32 bits
   function automatic logic signed [31:0] round_q16(longint x);
      longint q;
      q = (x + 64'sd32) >>> 6;
      if (q > 64'sd2147483647) begin
         q = 64'sd2147483647;
      end
      if (q < -64'sd2147483648) begin
         q = -64'sd2147483648;
      end
      return q[31:0];
   endfunction

   // update the shadow store, or queue the four fine cells of an interpolate
   function automatic void apply_request(face_req_type it);
      int            a;
      int            b;
      int            v;
      int            na;
      int            nb;
      longint        s [3];
      fine_cell_type r;
      a = int'(it.coarse_a);
      b = int'(it.coarse_b);
      v = int'(it.vsel);
      if (it.kind == KIND_LOAD) begin
         if (in_store(int'(it.plane), a, b, v)) begin
            coarse_copy[store_index(int'(it.plane), a, b, v)] = it.value;
         end
      end else begin
         for (int sa = 0; sa < 2; sa++) begin
            na = clamp_neighbour(a, sa, int'(cfg_last_a));
            for (int sb = 0; sb < 2; sb++) begin
               nb = clamp_neighbour(b, sb, int'(cfg_last_b));
               for (int p = 0; p < 3; p++) begin
                  s[p] = 9 * coarse_at(p, a, b, v) +
                         3 * (coarse_at(p, na, b, v) + coarse_at(p, a, nb, v)) +
                         coarse_at(p, na, nb, v);
               end
               r.fine_a       = 7'((a - int'(cfg_first_a)) * 2 + sa + 1);
               r.fine_b       = 7'((b - int'(cfg_first_b)) * 2 + sb + 1);
               r.var_out      = it.vsel;
               r.ghost_first  = round_q16(s[0] + 3 * s[1]);
               r.ghost_second = round_q16(3 * s[1] + s[2]);
               r.last         = (sa == 1 && sb == 1);
               expected_cells.push_back(r);
            end
         end
      end
   endfunction

   function automatic logic signed [31:0] rand_value();
      case (fill_mode)
         1: return 32'sh7FFF_FFFF;
         2: return 32'sh8000_0000;
         default: begin
            case ($urandom_range(0, 9))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sh0000_0000;
               3: return -32'sd1;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   function automatic void push_load(int p, int a, int b, int v, logic signed [31:0] val);
      face_req_type it;
      it.kind     = KIND_LOAD;
      it.plane    = 2'(p);
      it.coarse_a = 6'(a);
      it.coarse_b = 6'(b);
      it.vsel     = 3'(v);
      it.value    = val;
      if (in_store(p, a, b, v)) begin
         filled[store_index(p, a, b, v)] = 1'b1;
      end
      req_queue.push_back(it);
      items_queued++;
   endfunction

   // loads every stored cell that the interpolate will read and nobody loaded yet
   function automatic void push_interp(int a, int b, int v);
      face_req_type it;
      int           na;
      int           nb;
      int           ca [4];
      int           cb [4];
      for (int sa = 0; sa < 2; sa++) begin
         na = clamp_neighbour(a, sa, int'(cfg_last_a));
         for (int sb = 0; sb < 2; sb++) begin
            nb = clamp_neighbour(b, sb, int'(cfg_last_b));
            ca = '{a, na, a, na};
            cb = '{b, b, nb, nb};
            for (int p = 0; p < 3; p++) begin
               for (int k = 0; k < 4; k++) begin
                  if (in_store(p, ca[k], cb[k], v) && !filled[store_index(p, ca[k], cb[k], v)])
                  begin
                     push_load(p, ca[k], cb[k], v, rand_value());
                  end
               end
            end
         end
      end
      it.kind     = KIND_INTERP;
      it.plane    = 2'($urandom_range(0, 3));
      it.coarse_a = 6'(a);
      it.coarse_b = 6'(b);
      it.vsel     = 3'(v);
      it.value    = $urandom;
      req_queue.push_back(it);
      items_queued++;
   endfunction

   // mostly near the two clamp edges, now and then outside the store
   function automatic int pick_coarse();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) begin
         return 0;
      end else if (r == 1) begin
         return $urandom_range(33, 63);
      end else if (r < 11) begin
         return $urandom_range(1, 5);
      end
      return $urandom_range(28, 32);
   endfunction

   function automatic int pick_window();
      return $urandom_range(0, 1) ? $urandom_range(1, 5) : $urandom_range(28, 32);
   endfunction

   function automatic void random_phase(int count);
      int start;
      int noise;
      int r;
      start = items_queued;
      noise = 0;
      while (items_queued - start - noise < count) begin
         r = $urandom_range(0, 9);
         if (r < 7) begin
            push_interp(pick_coarse(), pick_coarse(),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
         end else if (r < 9) begin
            push_load($urandom_range(0, 2), pick_window(), pick_window(),
                      $urandom_range(0, 4), rand_value());
         end else begin
            // load that the block must drop
            case ($urandom_range(0, 4))
               0: push_load(3, pick_window(), pick_window(), $urandom_range(0, 4), $urandom);
               1: push_load($urandom_range(0, 2), 0, pick_window(), $urandom_range(0, 4),
                            $urandom);
               2: push_load($urandom_range(0, 2), $urandom_range(33, 63), pick_window(),
                            $urandom_range(0, 4), $urandom);
               3: push_load($urandom_range(0, 2), pick_window(), $urandom_range(33, 63),
                            $urandom_range(0, 4), $urandom);
               default: push_load($urandom_range(0, 3), pick_window(), pick_window(),
                                  $urandom_range(5, 7), $urandom);
            endcase
            noise++;
         end
      end
   endfunction

   task automatic program_face(logic [2:0] face, logic [5:0] fa, logic [5:0] fb,
                               logic [5:0] la, logic [5:0] lb);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FACE_SELECT;
      csr_wdata <= 6'(face);
      cfg_face   = face;
      @(posedge clock);
      csr_index <= CSR_FIRST_COARSE_A;
      csr_wdata <= fa;
      cfg_first_a = fa;
      @(posedge clock);
      csr_index <= CSR_FIRST_COARSE_B;
      csr_wdata <= fb;
      cfg_first_b = fb;
      @(posedge clock);
      csr_index <= CSR_COARSE_LAST_A;
      csr_wdata <= la;
      cfg_last_a = la;
      @(posedge clock);
      csr_index <= CSR_COARSE_LAST_B;
      csr_wdata <= lb;
      cfg_last_b = lb;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (items_accepted != items_queued || expected_cells.size() != 0);
      // a trailing load may still be in the block
      repeat (64) @(posedge clock);
   endtask

   task automatic flag_field(string what, longint e, longint a);
      if (e != a) begin
         $display("%0t: %s expected %0d, actual %0d", $time, what, e, a);
         mismatches++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap   = 0;
      end else begin
         drv_busy = req_valid;
         if (req_valid && req_ready) begin
            apply_request(drv_item);
            items_accepted++;
            drv_busy = 1'b0;
            if (!calm && $urandom_range(0, 3) == 0) begin
               send_gap = $urandom_range(1, 10);
            end
         end
         if (!drv_busy) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (req_queue.size() > 0) begin
               drv_item      = req_queue.pop_front();
               req_valid    <= 1'b1;
               req_kind     <= drv_item.kind;
               req_plane    <= drv_item.plane;
               req_coarse_a <= drv_item.coarse_a;
               req_coarse_b <= drv_item.coarse_b;
               req_variable <= drv_item.vsel;
               req_value    <= drv_item.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cells.size() == 0) begin
               $display("%0t: no result expected, actual fine_a %0d fine_b %0d", $time,
                        rsp_fine_a, rsp_fine_b);
               mismatches++;
            end else begin
               fine_cell_type e;
               e = expected_cells.pop_front();
               flag_field("fine_a", e.fine_a, rsp_fine_a);
               flag_field("fine_b", e.fine_b, rsp_fine_b);
               flag_field("var_out", e.var_out, rsp_var_out);
               flag_field("ghost_first", e.ghost_first, rsp_ghost_first);
               flag_field("ghost_second", e.ghost_second, rsp_ghost_second);
               flag_field("last", e.last, rsp_last);
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            recv_stall = $urandom_range(0, 9);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset register values: full-scale data at both corners
      fill_mode = 1;
      push_interp(1, 1, 0);
      fill_mode = 2;
      push_interp(32, 32, 4);
      fill_mode = 0;
      // loads outside the store must leave it untouched
      push_load(3, 1, 1, 0, $urandom);
      push_load(0, 0, 1, 0, $urandom);
      push_load(1, 33, 1, 0, $urandom);
      push_load(2, 1, 63, 0, $urandom);
      push_load(0, 1, 1, 5, $urandom);
      push_load(1, 1, 1, 7, $urandom);
      push_interp(1, 1, 0);
      push_load(1, 1, 1, 0, rand_value());
      push_interp(1, 1, 0);
      // cells outside the store read as zero, then one interpolate inside it
      push_interp(0, 0, 1);
      push_interp(63, 63, 2);
      push_interp(16, 17, 6);
      push_interp(2, 2, 7);
      push_interp(31, 2, 3);
      random_phase(50);
      wait_drained();

      // tightest clamp, fine numbering wraps below the origin
      program_face(3'd5, 6'd32, 6'd32, 6'd1, 6'd1);
      random_phase(60);
      wait_drained();

      // clamp beyond the store along a, zero clamp along b
      program_face(3'd7, 6'd63, 6'd0, 6'd63, 6'd0);
      random_phase(50);
      wait_drained();

      program_face(3'd2, 6'd2, 6'd5, 6'd7, 6'd30);
      random_phase(60);
      wait_drained();

      // closing stretch at full rate
      program_face(3'd0, 6'd1, 6'd1, 6'd32, 6'd32);
      calm = 1'b1;
      random_phase(60);
      wait_drained();

      if (mismatches == 0 && expected_cells.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: filelist.f
rtl/cffi_pkg.sv
rtl/coarse_to_fine_face_interpolator.sv
sim/coarse_to_fine_face_interpolator_tb.sv
